// ----- rtl/ahd_pkg.sv -----
// ----------------------------------------------------------------------------
// ahd_pkg: shared types and constants for the attack/hold/decay tint envelope
// Envelope stage codes and the fixed width of the frame-count fields.
// ----------------------------------------------------------------------------
package ahd_pkg;

    // attack, decay and hold frame counts arrive as 16-bit fields
    localparam int LEN_W = 16;

    typedef enum logic [1:0] {
        STAGE_IDLE   = 2'd0,
        STAGE_ATTACK = 2'd1,
        STAGE_DECAY  = 2'd2,
        STAGE_HOLD   = 2'd3
    } stage_t;

endpackage

// ----- rtl/ahd_div.sv -----
// ----------------------------------------------------------------------------
// ahd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// done pulses for one cycle; quo holds until the next start.
// ----------------------------------------------------------------------------
module ahd_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                // quotient bits shift in where numerator bits shift out
                num_reg <= {num_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

// ----- rtl/ahd_sqacc.sv -----
// ----------------------------------------------------------------------------
// ahd_sqacc: squared-magnitude accumulator
// One squarer, reused for the three operands in turn; sum is the sum of the
// three squared magnitudes.
// ----------------------------------------------------------------------------
module ahd_sqacc #(
    parameter int OP_W = 19
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [OP_W-1:0] op [3],
    output logic                   done,
    output logic [2*OP_W-1:0]      sum
);

    localparam int MAG_W = OP_W - 1;
    localparam int SUM_W = 2 * OP_W;

    logic [1:0]         k_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [2*MAG_W-1:0] prod_reg;
    logic [SUM_W-1:0]   acc_reg;

    logic signed [OP_W-1:0] cur;
    logic        [OP_W-1:0] mag_full;
    logic        [MAG_W-1:0] mag;

    always_comb begin
        case (k_reg)
            2'd0:    cur = op[0];
            2'd1:    cur = op[1];
            default: cur = op[2];
        endcase
    end

    // operands never reach -2^(OP_W-1), so the magnitude fits MAG_W bits
    assign mag_full = cur[OP_W-1] ? OP_W'(-cur) : OP_W'(cur);
    assign mag      = mag_full[MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                if (k_reg != 2'd3) begin
                    prod_reg <= mag * mag;
                end
                if (k_reg != 2'd0) begin
                    acc_reg <= acc_reg + SUM_W'(prod_reg);
                end
                if (k_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

// ----- rtl/rgb_attack_hold_decay_envelope_core.sv -----
// ----------------------------------------------------------------------------
// rgb_attack_hold_decay_envelope_core: RGB tint envelope
// Attack/hold/decay tint ramp; play words load a peak and frame counts,
// tick words advance one frame. One shared divider and one shared squarer.
// ----------------------------------------------------------------------------
// Play word: six passes through the bit-serial divider plus one squarer pass.
// Tick word: no squarer pass in idle or hold, two squarer passes in attack or
//   decay. One word at a time; s_ready returns as the result goes valid.
// Reset (aresetn low, synchronous) zeroes the tint and envelope state,
//   stage idle; no clearing pass.
module rgb_attack_hold_decay_envelope_core #(
    parameter int FRAC_BITS  = 16,
    parameter int FRAME_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [FRAC_BITS:0]          s_peak_red,
    input  logic [FRAC_BITS:0]          s_peak_green,
    input  logic [FRAC_BITS:0]          s_peak_blue,
    input  logic [ahd_pkg::LEN_W-1:0]   s_attack_length,
    input  logic [ahd_pkg::LEN_W-1:0]   s_decay_length,
    input  logic [ahd_pkg::LEN_W-1:0]   s_hold_length,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [FRAC_BITS+1:0] m_tint_red,
    output logic signed [FRAC_BITS+1:0] m_tint_green,
    output logic signed [FRAC_BITS+1:0] m_tint_blue,
    output logic                        m_tinted,
    output logic [1:0]                  m_stage
);

    localparam int LEN_W  = ahd_pkg::LEN_W;
    localparam int TINT_W = FRAC_BITS + 2;
    localparam int PEAK_W = FRAC_BITS + 1;
    localparam int DIFF_W = TINT_W + 1;
    localparam int SUM_W  = 2 * DIFF_W;
    localparam int EPS    = ((1 << FRAC_BITS) + 500) / 1000;
    localparam logic [SUM_W-1:0] EPS2 = SUM_W'(EPS * EPS);
    localparam logic signed [TINT_W-1:0] TINT_MAX = {1'b0, {(TINT_W-1){1'b1}}};
    localparam logic signed [TINT_W-1:0] TINT_MIN = {1'b1, {(TINT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_DONE
    } fsm_t;

    typedef enum logic [1:0] {
        SEL_DIST,
        SEL_ASTEP,
        SEL_TINT,
        SEL_DSTEP
    } sel_t;

    fsm_t                     state_reg;
    sel_t                     sel_reg;
    ahd_pkg::stage_t          stage_reg;
    logic                     active_reg;
    logic                     play_reg;
    logic                     second_reg;
    logic [2:0]               div_idx_reg;
    logic [LEN_W-1:0]         alen_reg;
    logic [LEN_W-1:0]         dlen_reg;
    logic [FRAME_BITS-1:0]    hold_reg;
    logic [SUM_W-1:0]         sum_a_reg;
    logic signed [TINT_W-1:0] tint_reg  [3];
    logic        [PEAK_W-1:0] peak_reg  [3];
    logic signed [TINT_W-1:0] astep_reg [3];
    logic signed [TINT_W-1:0] dstep_reg [3];

    logic                     m_valid_reg;
    logic signed [TINT_W-1:0] m_tint_reg [3];
    logic                     m_tinted_reg;
    logic [1:0]               m_stage_reg;

    // combinational helpers
    logic signed [DIFF_W-1:0] diff      [3];
    logic signed [DIFF_W-1:0] sq_op     [3];
    logic signed [TINT_W-1:0] add_step  [3];
    logic signed [DIFF_W-1:0] add_sum   [3];
    logic signed [TINT_W-1:0] tint_step [3];
    logic [LEN_W+FRAME_BITS-1:0] hold_wide;
    logic [FRAME_BITS-1:0]    hold_in;
    logic [1:0]               div_ch;
    logic [DIFF_W-1:0]        diff_mag;
    logic [TINT_W-1:0]        div_num;
    logic                     div_neg;
    logic [LEN_W-1:0]         div_den;
    logic                     div_start;
    logic                     div_done;
    logic [TINT_W-1:0]        div_quo;
    logic [TINT_W-1:0]        quo_neg;
    logic signed [TINT_W-1:0] step_sat;
    logic                     sq_start;
    logic                     sq_done;
    logic [SUM_W-1:0]         sq_sum;
    logic                     advance;
    logic                     accept;
    logic                     out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign hold_wide = {{FRAME_BITS{1'b0}}, s_hold_length};
    assign hold_in   = hold_wide[FRAME_BITS-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i]     = $signed({2'b00, peak_reg[i]}) - DIFF_W'(tint_reg[i]);
            add_step[i] = (stage_reg == ahd_pkg::STAGE_DECAY) ? dstep_reg[i] : astep_reg[i];
            add_sum[i]  = DIFF_W'(tint_reg[i]) + DIFF_W'(add_step[i]);
            if (add_sum[i][DIFF_W-1] != add_sum[i][TINT_W-1]) begin
                tint_step[i] = add_sum[i][DIFF_W-1] ? TINT_MIN : TINT_MAX;
            end else begin
                tint_step[i] = add_sum[i][TINT_W-1:0];
            end
            case (sel_reg)
                SEL_DIST:  sq_op[i] = diff[i];
                SEL_ASTEP: sq_op[i] = DIFF_W'(astep_reg[i]);
                SEL_TINT:  sq_op[i] = DIFF_W'(tint_reg[i]);
                default:   sq_op[i] = DIFF_W'(dstep_reg[i]);
            endcase
        end
    end

    // divide order: attack steps red..blue, then decay steps red..blue
    assign div_ch = (div_idx_reg < 3'd3) ? div_idx_reg[1:0] : 2'(div_idx_reg - 3'd3);

    always_comb begin
        diff_mag = diff[div_ch][DIFF_W-1] ? DIFF_W'(-diff[div_ch]) : DIFF_W'(diff[div_ch]);
        if (div_idx_reg < 3'd3) begin
            div_num = diff_mag[TINT_W-1:0];
            div_neg = diff[div_ch][DIFF_W-1];
            div_den = alen_reg;
        end else begin
            div_num = TINT_W'(peak_reg[div_ch]);
            div_neg = 1'b1;
            div_den = dlen_reg;
        end
    end

    // truncating divide on magnitudes, then sign and saturate
    assign quo_neg = TINT_W'(-div_quo);
    always_comb begin
        if (div_neg) begin
            step_sat = (div_quo[TINT_W-1] && (|div_quo[TINT_W-2:0])) ? TINT_MIN
                                                                     : $signed(quo_neg);
        end else begin
            step_sat = div_quo[TINT_W-1] ? TINT_MAX : $signed(div_quo);
        end
    end

    assign div_start = (state_reg == S_DIV_GO);
    assign sq_start  = (state_reg == S_SQ_GO);
    assign advance   = (sum_a_reg >= sq_sum) && (sum_a_reg > EPS2);

    ahd_div #(
        .NUM_W (TINT_W),
        .DEN_W (LEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    ahd_sqacc #(
        .OP_W (DIFF_W)
    ) u_sqacc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .op      (sq_op),
        .done    (sq_done),
        .sum     (sq_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sel_reg     <= SEL_DIST;
            stage_reg   <= ahd_pkg::STAGE_IDLE;
            active_reg  <= 1'b0;
            play_reg    <= 1'b0;
            second_reg  <= 1'b0;
            div_idx_reg <= '0;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                tint_reg[i]  <= '0;
                peak_reg[i]  <= '0;
                astep_reg[i] <= '0;
                dstep_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        play_reg   <= s_mode;
                        second_reg <= 1'b0;
                        if (s_mode) begin
                            peak_reg[0] <= s_peak_red;
                            peak_reg[1] <= s_peak_green;
                            peak_reg[2] <= s_peak_blue;
                            alen_reg    <= (s_attack_length == '0) ? LEN_W'(1) : s_attack_length;
                            dlen_reg    <= (s_decay_length == '0) ? LEN_W'(1) : s_decay_length;
                            hold_reg    <= hold_in;
                            div_idx_reg <= '0;
                            state_reg   <= S_DIV_GO;
                        end else begin
                            unique case (stage_reg)
                                ahd_pkg::STAGE_IDLE: begin
                                    for (int i = 0; i < 3; i++) tint_reg[i] <= '0;
                                    active_reg <= 1'b0;
                                    state_reg  <= S_DONE;
                                end
                                ahd_pkg::STAGE_HOLD: begin
                                    if (hold_reg != '0) begin
                                        hold_reg <= hold_reg - FRAME_BITS'(1);
                                    end else begin
                                        stage_reg <= ahd_pkg::STAGE_DECAY;
                                    end
                                    state_reg <= S_DONE;
                                end
                                ahd_pkg::STAGE_ATTACK: begin
                                    sel_reg   <= SEL_DIST;
                                    state_reg <= S_SQ_GO;
                                end
                                default: begin
                                    sel_reg   <= SEL_TINT;
                                    state_reg <= S_SQ_GO;
                                end
                            endcase
                        end
                    end
                end
                S_DIV_GO: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (div_idx_reg < 3'd3) begin
                            astep_reg[div_ch] <= step_sat;
                        end else begin
                            dstep_reg[div_ch] <= step_sat;
                        end
                        if (div_idx_reg == 3'd5) begin
                            sel_reg   <= SEL_DIST;
                            state_reg <= S_SQ_GO;
                        end else begin
                            div_idx_reg <= div_idx_reg + 3'd1;
                            state_reg   <= S_DIV_GO;
                        end
                    end
                end
                S_SQ_GO: begin
                    state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (sq_done) begin
                        if (play_reg) begin
                            // already at the peak: go straight to hold, else start the attack
                            stage_reg  <= (sq_sum <= EPS2) ? ahd_pkg::STAGE_HOLD
                                                           : ahd_pkg::STAGE_ATTACK;
                            active_reg <= 1'b1;
                            state_reg  <= S_DONE;
                        end else if (!second_reg) begin
                            sum_a_reg  <= sq_sum;
                            second_reg <= 1'b1;
                            sel_reg    <= (stage_reg == ahd_pkg::STAGE_ATTACK) ? SEL_ASTEP
                                                                               : SEL_DSTEP;
                            state_reg  <= S_SQ_GO;
                        end else begin
                            if (advance) begin
                                for (int i = 0; i < 3; i++) tint_reg[i] <= tint_step[i];
                                active_reg <= 1'b1;
                            end else if (stage_reg == ahd_pkg::STAGE_ATTACK) begin
                                stage_reg <= (hold_reg != '0) ? ahd_pkg::STAGE_HOLD
                                                              : ahd_pkg::STAGE_DECAY;
                            end else begin
                                stage_reg  <= ahd_pkg::STAGE_IDLE;
                                active_reg <= 1'b0;
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // result payload, loaded with the committed envelope state
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        for (int i = 0; i < 3; i++) m_tint_reg[i] <= tint_reg[i];
                        m_tinted_reg <= active_reg;
                        m_stage_reg  <= stage_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_tint_red   = m_tint_reg[0];
    assign m_tint_green = m_tint_reg[1];
    assign m_tint_blue  = m_tint_reg[2];
    assign m_tinted     = m_tinted_reg;
    assign m_stage      = m_stage_reg;

endmodule

// ----- rtl/ahd_check.sv -----
// ----------------------------------------------------------------------------
// ahd_check: port-level checks for the tint envelope core
// Watches the handshakes and the reported stage/tinted flags.
// ----------------------------------------------------------------------------
module ahd_check #(
    parameter int FRAC_BITS = 16
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [FRAC_BITS+1:0] m_tint_red,
    input logic                        m_tinted,
    input logic [1:0]                  m_stage
);

    // an accept always moves the core out of idle, so ready drops right after it
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input accepted on back-to-back cycles");

    // idle always reports no tint applied
    a_idle_untinted: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stage == ahd_pkg::STAGE_IDLE) |-> !m_tinted
    ) else $error("idle stage reported with tint applied");

    // attack and hold always carry an applied tint
    a_ramp_tinted: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_stage == ahd_pkg::STAGE_ATTACK || m_stage == ahd_pkg::STAGE_HOLD))
            |-> m_tinted
    ) else $error("attack or hold stage without tint");

    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_tint_red) && $stable(m_stage))
    ) else $error("stalled result word changed");

endmodule

bind rgb_attack_hold_decay_envelope_core ahd_check #(
    .FRAC_BITS (FRAC_BITS)
) u_ahd_check (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_tint_red (m_tint_red),
    .m_tinted   (m_tinted),
    .m_stage    (m_stage)
);
